// ===== src/cia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Checked integer ALU package
// Operation and operand type codes, and the side band word that travels
// down the pipeline next to the multiplier data.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;

  localparam logic [2:0] KIND_U16 = 3'd0;
  localparam logic [2:0] KIND_U32 = 3'd1;
  localparam logic [2:0] KIND_S32 = 3'd2;
  localparam logic [2:0] KIND_U64 = 3'd3;
  localparam logic [2:0] KIND_S64 = 3'd4;

  localparam int unsigned HalfBits = 32;

  typedef struct packed {
    logic        valid_op;
    logic        is_mul;
    logic [2:0]  kind;
    logic        neg;
    logic [63:0] as_value;
    logic        as_ovf;
  } side_t;

endpackage
`default_nettype wire

// ===== src/cia_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Checked integer ALU operand stage
// Truncates and extends the operands, completes add and subtract with their
// overflow check, and forms the multiplier magnitudes and product sign.
// ----------------------------------------------------------------------------
module cia_prep import cia_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [1:0]  func_i,
  input  wire logic [2:0]  kind_i,
  input  wire logic [63:0] operand_a_i,
  input  wire logic [63:0] operand_b_i,
  output side_t            side_o,
  output logic [63:0]      mag_a_o,
  output logic [63:0]      mag_b_o
);

  logic [64:0] xa, xb, sum;
  logic        as_ovf;
  logic [63:0] as_value;
  side_t       side_d, side_q;
  logic [63:0] mag_a_d, mag_b_d, mag_a_q, mag_b_q;

  always_comb begin
    case (kind_i)
      KIND_U16: begin
        xa = {49'd0, operand_a_i[15:0]};
        xb = {49'd0, operand_b_i[15:0]};
      end
      KIND_U32: begin
        xa = {33'd0, operand_a_i[31:0]};
        xb = {33'd0, operand_b_i[31:0]};
      end
      KIND_S32: begin
        xa = {{33{operand_a_i[31]}}, operand_a_i[31:0]};
        xb = {{33{operand_b_i[31]}}, operand_b_i[31:0]};
      end
      KIND_U64: begin
        xa = {1'b0, operand_a_i};
        xb = {1'b0, operand_b_i};
      end
      KIND_S64: begin
        xa = {operand_a_i[63], operand_a_i};
        xb = {operand_b_i[63], operand_b_i};
      end
      default: begin
        xa = '0;
        xb = '0;
      end
    endcase
  end

  assign sum = (func_i == FUNC_SUB) ? (xa - xb) : (xa + xb);

  always_comb begin
    case (kind_i)
      KIND_U16: begin
        as_ovf   = |sum[64:16];
        as_value = {48'd0, sum[15:0]};
      end
      KIND_U32: begin
        as_ovf   = |sum[64:32];
        as_value = {32'd0, sum[31:0]};
      end
      KIND_S32: begin
        as_ovf   = !((&sum[64:31]) || !(|sum[64:31]));
        as_value = {{32{sum[31]}}, sum[31:0]};
      end
      KIND_U64: begin
        as_ovf   = sum[64];
        as_value = sum[63:0];
      end
      KIND_S64: begin
        as_ovf   = sum[64] ^ sum[63];
        as_value = as_ovf ? 64'd0 : sum[63:0];
      end
      default: begin
        as_ovf   = 1'b0;
        as_value = '0;
      end
    endcase
  end

  always_comb begin
    side_d.valid_op = (func_i <= FUNC_MUL) && (kind_i <= KIND_S64);
    side_d.is_mul   = (func_i == FUNC_MUL);
    side_d.kind     = kind_i;
    side_d.neg      = xa[64] ^ xb[64];
    side_d.as_value = as_value;
    side_d.as_ovf   = as_ovf;
    mag_a_d         = xa[64] ? (64'd0 - xa[63:0]) : xa[63:0];
    mag_b_d         = xb[64] ? (64'd0 - xb[63:0]) : xb[63:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q  <= side_d;
      mag_a_q <= mag_a_d;
      mag_b_q <= mag_b_d;
    end
  end

  assign side_o  = side_q;
  assign mag_a_o = mag_a_q;
  assign mag_b_o = mag_b_q;

endmodule
`default_nettype wire

// ===== src/cia_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Checked integer ALU multiplier
// A 64 by 64 unsigned multiplier in two stages: four registered 32 by 32
// partial products, then their sum into the full 128-bit product.
// ----------------------------------------------------------------------------
module cia_mul import cia_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire side_t        side_i,
  input  wire logic [63:0]  mag_a_i,
  input  wire logic [63:0]  mag_b_i,
  output side_t             side_o,
  output logic [127:0]      prod_o
);

  logic [HalfBits-1:0] a0, a1, b0, b1;
  logic [63:0]         p00_q, p01_q, p10_q, p11_q;
  side_t               side1_q, side2_q;
  logic [127:0]        prod_d, prod_q;

  assign a0 = mag_a_i[HalfBits-1:0];
  assign a1 = mag_a_i[63:HalfBits];
  assign b0 = mag_b_i[HalfBits-1:0];
  assign b1 = mag_b_i[63:HalfBits];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q   <= a0 * b0;
      p01_q   <= a0 * b1;
      p10_q   <= a1 * b0;
      p11_q   <= a1 * b1;
      side1_q <= side_i;
    end
  end

  assign prod_d = {p11_q, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      side2_q <= side1_q;
    end
  end

  assign side_o = side2_q;
  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== src/cia_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Checked integer ALU result stage
// Applies the product sign, checks the product against the type's range and
// selects the final word into the output register.
// ----------------------------------------------------------------------------
module cia_fmt import cia_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire side_t        side_i,
  input  wire logic [127:0] prod_i,
  output logic [63:0]       value_o,
  output logic              overflow_o
);

  logic [63:0] slow;
  logic        m_ovf;
  logic [63:0] m_value;
  logic [63:0] value_d, value_q;
  logic        ovf_d, ovf_q;

  assign slow = side_i.neg ? (64'd0 - prod_i[63:0]) : prod_i[63:0];

  always_comb begin
    case (side_i.kind)
      KIND_U16: begin
        m_ovf   = |prod_i[127:16];
        m_value = {48'd0, prod_i[15:0]};
      end
      KIND_U32: begin
        m_ovf   = |prod_i[127:32];
        m_value = {32'd0, prod_i[31:0]};
      end
      KIND_S32: begin
        m_ovf   = side_i.neg ? (prod_i[63:0] > 64'h0000_0000_8000_0000) : (|prod_i[63:31]);
        m_value = {{32{slow[31]}}, slow[31:0]};
      end
      KIND_U64: begin
        m_ovf   = |prod_i[127:64];
        m_value = prod_i[63:0];
      end
      KIND_S64: begin
        m_ovf   = (|prod_i[127:64]) ||
                  (side_i.neg ? (prod_i[63:0] > 64'h8000_0000_0000_0000) : prod_i[63]);
        m_value = m_ovf ? 64'd0 : slow;
      end
      default: begin
        m_ovf   = 1'b0;
        m_value = '0;
      end
    endcase
  end

  always_comb begin
    if (!side_i.valid_op) begin
      value_d = '0;
      ovf_d   = 1'b0;
    end else if (side_i.is_mul) begin
      value_d = m_value;
      ovf_d   = m_ovf;
    end else begin
      value_d = side_i.as_value;
      ovf_d   = side_i.as_ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
      ovf_q   <= ovf_d;
    end
  end

  assign value_o    = value_q;
  assign overflow_o = ovf_q;

endmodule
`default_nettype wire

// ===== src/checked_integer_alu_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Checked integer ALU
// Add, subtract or multiply on u16, u32, s32, u64 or s64 operands with an
// overflow flag.
//
// One input word carries func_i, kind_i and two 64-bit operands; it is taken
// when in_valid_i and in_ready_o are both high. Exactly one output word of
// value_o and overflow_o follows, taken when out_valid_o and out_ready_i are
// both high. Results leave in the order that the words came in.
// The pipeline has four register stages: operand preparation with the whole
// add and subtract path, the 32 by 32 partial products, the 128-bit product
// sum, and the output register with range check and sign. One word is
// accepted every cycle unless a result waits at the output untaken.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o falls; it rises again in the cycle the receiver takes the
// result. Bubbles in the pipeline do not hold it back while the output is
// empty. Reset clears the stage valid bits only, so the block comes out of
// reset empty and ready.
// ----------------------------------------------------------------------------
module checked_integer_alu_unit import cia_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [2:0]  kind_i,
  input  wire logic [63:0] operand_a_i,
  input  wire logic [63:0] operand_b_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      value_o,
  output logic             overflow_o
);

  localparam int unsigned Stages = 4;

  logic [Stages-1:0] valid_d, valid_q;
  logic              en;
  side_t             side_p, side_m;
  logic [63:0]       mag_a, mag_b;
  logic [127:0]      prod;

  assign en = !valid_q[Stages-1] || out_ready_i;

  assign valid_d = {valid_q[Stages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  cia_prep u_prep (
    .clk_i       (clk_i),
    .en_i        (en),
    .func_i      (func_i),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .side_o      (side_p),
    .mag_a_o     (mag_a),
    .mag_b_o     (mag_b)
  );

  cia_mul u_mul (
    .clk_i   (clk_i),
    .en_i    (en),
    .side_i  (side_p),
    .mag_a_i (mag_a),
    .mag_b_i (mag_b),
    .side_o  (side_m),
    .prod_o  (prod)
  );

  cia_fmt u_fmt (
    .clk_i      (clk_i),
    .en_i       (en),
    .side_i     (side_m),
    .prod_i     (prod),
    .value_o    (value_o),
    .overflow_o (overflow_o)
  );

  assign in_ready_o  = en;
  assign out_valid_o = valid_q[Stages-1];

endmodule
`default_nettype wire

// ===== src/cia_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Checked integer ALU port checker
// Watches the ports of the top level for handshake rules, latency and
// readiness, and is bound to every instance of it.
// ----------------------------------------------------------------------------
module cia_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  func_i,
  input wire logic [2:0]  kind_i,
  input wire logic [63:0] operand_a_i,
  input wire logic [63:0] operand_b_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] value_o,
  input wire logic        overflow_o
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word withdrawn before it was taken");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(value_o) && $stable(overflow_o))
    else $error("output word changed while stalled");

  // With an empty output register the block always takes a new word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output register");

  // A word accepted while the receiver then stays ready shows its result once it has passed the pipeline registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o)
    else $error("result missing after the pipeline latency");

endmodule

bind checked_integer_alu_unit cia_checker u_cia_checker (.*);
`default_nettype wire
